[src/assert_macros.svh]
// assertion helpers shared by the spectrum bar modules
// expects i_clk and i_rst_n in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SBF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbf_pkg.sv]
// shared constants, types and codes for the spectrum bar falloff / peak hold block
// no dependencies
`timescale 1ns / 1ps

package sbf_pkg;

    // geometry
    localparam int COLUMNS  = 64;
    localparam int LEVELS   = 64;
    localparam int SLOTS    = 3 * COLUMNS;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int LEVEL_W  = $clog2(LEVELS);
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int HEIGHT_W = 8;
    localparam int MODE_W   = 2;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

    // channel mode codes
    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;

    // configuration register indexes
    localparam logic CFG_BAR_HEIGHT = 1'b0;
    localparam logic CFG_PEAKS_EN   = 1'b1;

    // one stored column entry (previous height is the old show, not stored)
    typedef struct packed {
        logic [HEIGHT_W-1:0] show;
        logic [HEIGHT_W-1:0] peak;
        logic [HEIGHT_W-1:0] fall;
    } t_entry;

    // write-back request from the update stage to the column store
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [SLOT_W-1:0] slot;
        t_entry            data;
    } t_wr_req;

endpackage

[src/sbf_update.sv]
// next-state logic for one bar: level select, scaling, falloff and peak hold
// depends on sbf_pkg
`timescale 1ns / 1ps

module sbf_update import sbf_pkg::*; (
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [LEVEL_W-1:0]  i_level_left,
    input  logic [LEVEL_W-1:0]  i_level_right,
    input  logic [HEIGHT_W-1:0] i_bar_height,
    input  t_entry              i_old,
    output t_entry              o_new
);

    localparam int PROD_W = LEVEL_W + HEIGHT_W;

    logic [LEVEL_W-1:0]  w_lv;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_scaled;
    logic [HEIGHT_W-1:0] w_lvl;
    logic [HEIGHT_W-1:0] w_show;
    logic [HEIGHT_W-1:0] w_fall;
    logic [HEIGHT_W-1:0] w_peak;

    // level select by channel mode
    always_comb begin
        case (i_mode)
            MODE_LEFT:  w_lv = i_level_left;
            MODE_RIGHT: w_lv = i_level_right;
            default:    w_lv = (i_level_left > i_level_right) ? i_level_left : i_level_right;
        endcase
    end

    // scale to bar height, saturating
    assign w_prod   = PROD_W'(w_lv) * PROD_W'(i_bar_height);
    assign w_scaled = w_prod / PROD_W'(LEVELS);
    assign w_lvl    = (w_scaled > PROD_W'(HEIGHT_MAX)) ? HEIGHT_MAX : w_scaled[HEIGHT_W-1:0];

    // bar falloff with growing speed
    always_comb begin
        w_show = i_old.show;
        w_fall = i_old.fall;
        if (w_lvl < i_old.show) begin
            if (i_old.show >= i_old.fall) begin
                w_show = i_old.show - i_old.fall;
                if (i_old.fall != HEIGHT_MAX) begin
                    w_fall = i_old.fall + 1'b1;
                end
            end else begin
                w_show = '0;
            end
        end
        if (w_lvl > w_show) begin
            w_show = w_lvl;
            w_fall = HEIGHT_W'(1);
        end
    end

    // peak jumps above the level, else decays while clear of the bar
    always_comb begin
        w_peak = i_old.peak;
        if (i_old.peak <= w_lvl) begin
            w_peak = (w_lvl != HEIGHT_MAX) ? w_lvl + 1'b1 : HEIGHT_MAX;
        end else if ((i_old.peak != '0) &&
                     ({1'b0, i_old.peak} > ({1'b0, w_show} + 1'b1))) begin
            w_peak = i_old.peak - 1'b1;
        end
    end

    assign o_new.show = w_show;
    assign o_new.fall = w_fall;
    assign o_new.peak = w_peak;

endmodule

[src/sbf_store.sv]
// column state memory with per-entry valid bits and write-to-read forwarding
// depends on sbf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbf_store import sbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_slot,
    input  t_wr_req           i_wr,
    output t_entry            o_entry
);

    t_entry             r_mem [SLOTS];
    logic [SLOTS-1:0]   r_valid;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic               r_hit;
    logic               r_clr;
    t_entry             r_fwd;

    // memory port: registered read, one write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
        end
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
    end

    // valid bits, cleared all at once by reset or a clear transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            if (i_wr.clear) begin
                r_valid <= '0;
            end
            r_valid[i_wr.slot] <= 1'b1;
        end
    end

    // capture what the concurrent write does to this read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_clr    <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_valid[i_rd_slot];
            r_hit    <= i_wr.en && (i_wr.slot == i_rd_slot);
            r_clr    <= i_wr.en && i_wr.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd <= i_wr.data;
        end
    end

    // resolved read data
    always_comb begin
        if (r_hit) begin
            o_entry = r_fwd;
        end else if (r_clr || !r_rd_vld) begin
            o_entry = '0;
        end else begin
            o_entry = r_rd_data;
        end
    end

    `SBF_ASSERT_NEXT(a_clear_leaves_one, i_wr.en && i_wr.clear, $countones(r_valid) == 1, "clear did not leave exactly the written entry valid")
    `SBF_ASSERT_NEXT(a_write_sets_valid, i_wr.en, r_valid[$past(i_wr.slot)], "written entry not marked valid")
    `SBF_ASSERT_NEXT(a_hit_needs_write, i_rd_en && !i_wr.en, !r_hit && !r_clr, "forwarding flagged without a concurrent write")

endmodule

[src/spectrum_bar_falloff_peak_hold_top.sv]
// spectrum bar falloff / peak hold: input stage, update logic, result register
// depends on sbf_pkg, sbf_store, sbf_update and assert_macros.svh
//
// Usage:
//   Slave stream: one transaction per column update. tuser carries clear_all
//   and channel_mode, tdata carries column, left level and right level.
//   Master stream: one transaction per accepted input, tdata holds the new
//   show height, the previous show height and the peak height.
//   Config port: write bar_height (index 0) or peaks_enabled (index 1) at any
//   edge with i_cfg_wr_en high, only while no transaction is in flight.
// Timing:
//   A result passes the input stage, then the result register. One item is
//   taken per cycle unless the master side stalls: the column memory is read
//   at acceptance and written back from the update stage as it advances, with
//   forwarding for back-to-back updates of the same slot.
// Reset (synchronous, active low) empties the pipeline, marks every column
//   entry as zero through the valid bits and restores the register defaults;
//   no clearing pass is needed. A clear_all transaction does the same to the
//   column state.
// When the master side stalls, the result register holds and the input stage
//   keeps accepting until it is also full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spectrum_bar_falloff_peak_hold_top import sbf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [23:0]         i_s_tdata,   // column[5:0], level_left[11:6], level_right[17:12]
    input  logic [2:0]          i_s_tuser,   // clear_all[0], channel_mode[2:1]
    // master stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,   // show_height[7:0], prev_height[15:8], peak_height[23:16]
    // configuration write port
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_addr,
    input  logic [HEIGHT_W-1:0] i_cfg_data
);

    // configuration registers
    logic [HEIGHT_W-1:0] r_bar_height;
    logic                r_peaks_en;

    // input stage
    logic                r_a_valid;
    logic                r_a_clear;
    logic [MODE_W-1:0]   r_a_mode;
    logic [SLOT_W-1:0]   r_a_slot;
    logic [LEVEL_W-1:0]  r_a_lv_l;
    logic [LEVEL_W-1:0]  r_a_lv_r;

    // result register
    logic                r_o_valid;
    logic [HEIGHT_W-1:0] r_show;
    logic [HEIGHT_W-1:0] r_prev;
    logic [HEIGHT_W-1:0] r_peak;

    logic                w_s_acc;
    logic                w_a_adv;
    logic [MODE_W-1:0]   w_mode;
    logic [COL_W-1:0]    w_col;
    logic [SLOT_W-1:0]   w_slot;
    t_entry              w_stored;
    t_entry              w_old;
    t_entry              w_new;
    t_wr_req             w_wr;

    // handshake
    assign w_a_adv    = r_a_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || w_a_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // mode three behaves as both; slot = mode * COLUMNS + column
    assign w_mode = (i_s_tuser[2:1] > MODE_BOTH) ? MODE_BOTH : i_s_tuser[2:1];
    assign w_col  = i_s_tdata[COL_W-1:0];
    assign w_slot = SLOT_W'(w_mode) * SLOT_W'(COLUMNS) + SLOT_W'(w_col);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_height <= HEIGHT_W'(64);
            r_peaks_en   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_BAR_HEIGHT: r_bar_height <= i_cfg_data;
                CFG_PEAKS_EN:   r_peaks_en   <= i_cfg_data[0];
            endcase
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_a_clear <= i_s_tuser[0];
            r_a_mode  <= w_mode;
            r_a_slot  <= w_slot;
            r_a_lv_l  <= i_s_tdata[COL_W +: LEVEL_W];
            r_a_lv_r  <= i_s_tdata[COL_W+LEVEL_W +: LEVEL_W];
        end
    end

    sbf_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_s_acc),
        .i_rd_slot (w_slot),
        .i_wr      (w_wr),
        .o_entry   (w_stored)
    );

    // own clear zeroes the entry before the update
    assign w_old = r_a_clear ? '0 : w_stored;

    sbf_update u_update (
        .i_mode        (r_a_mode),
        .i_level_left  (r_a_lv_l),
        .i_level_right (r_a_lv_r),
        .i_bar_height  (r_bar_height),
        .i_old         (w_old),
        .o_new         (w_new)
    );

    // write-back request
    always_comb begin
        w_wr.en    = w_a_adv;
        w_wr.clear = r_a_clear;
        w_wr.slot  = r_a_slot;
        w_wr.data  = w_new;
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_show <= w_new.show;
            r_prev <= w_old.show;
            r_peak <= r_peaks_en ? w_new.peak : '0;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_peak, r_prev, r_show};

    `SBF_ASSERT_NEXT(a_stage_holds, r_a_valid && !w_a_adv && !w_s_acc, r_a_valid && $stable(r_a_slot), "input stage lost or changed a waiting transaction")
    `SBF_ASSERT_ALWAYS(a_result_from_stage, !$rose(r_o_valid) || $past(r_a_valid), "result appeared without a transaction in the input stage")
    `SBF_ASSERT_ALWAYS(a_slot_in_range, !r_a_valid || (r_a_slot < SLOT_W'(SLOTS)), "slot index beyond the column store")

endmodule
